// ===== src/spc_pkg.sv =====
`timescale 1ns / 1ps

package spc_pkg;

    localparam int MAX_NODES_DEF   = 64;
    localparam int WEIGHT_BITS_DEF = 16;

    localparam int KIND_W  = 2;
    localparam int NODE_W  = 6;
    localparam int FIELD_W = 16;
    localparam int OUT_W   = 22;
    localparam int COUNT_W = 7;
    localparam int CIDX_W  = 2;

    localparam logic [OUT_W-1:0] OUT_MAX = 22'h3fffff;

    typedef enum logic [KIND_W-1:0] {
        K_LOAD  = 2'd0,
        K_RUN   = 2'd1,
        K_CLEAR = 2'd2,
        K_NONE  = 2'd3
    } t_kind;

    typedef enum logic [CIDX_W-1:0] {
        C_NODE_COUNT = 2'd0,
        C_SOURCE     = 2'd1,
        C_DEST       = 2'd2,
        C_UNUSED     = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD2,
        S_INIT,
        S_PASS,
        S_READ_DEST,
        S_RESULT
    } t_state;

endpackage

// ===== src/spc_edge_ram.sv =====
`timescale 1ns / 1ps

module spc_edge_ram #(
    parameter int DEPTH  = 4096,
    parameter int AW     = 12,
    parameter int DATA_W = 33
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/shortest_path_cost_tiebreak.sv =====
`timescale 1ns / 1ps

// channel  direction  handshake                  payload
// in       input      i_in_valid / o_in_ready    i_kind i_node_a i_node_b i_edge_length i_edge_cost
// out      output     o_out_valid / i_out_ready  o_reachable o_path_length o_path_cost
// cfg      input      i_cfg_we                   i_cfg_index i_cfg_data
//
// a load writes both directions to the edge memory (a to b on acceptance, b to a in
// S_LOAD2), a clear sweeps all MAX_NODES*MAX_NODES entries of the edge memory, a run
// reads one edge memory word per candidate neighbor for each settled node of n active nodes.
// after reset the same MAX_NODES*MAX_NODES sweep runs before the first item.
// a run result waits in the output register; loads and clears go on meanwhile.

module shortest_path_cost_tiebreak #(
    parameter int MAX_NODES   = spc_pkg::MAX_NODES_DEF,
    parameter int WEIGHT_BITS = spc_pkg::WEIGHT_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [spc_pkg::KIND_W-1:0]   i_kind,
    input  logic [spc_pkg::NODE_W-1:0]   i_node_a,
    input  logic [spc_pkg::NODE_W-1:0]   i_node_b,
    input  logic [spc_pkg::FIELD_W-1:0]  i_edge_length,
    input  logic [spc_pkg::FIELD_W-1:0]  i_edge_cost,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_reachable,
    output logic [spc_pkg::OUT_W-1:0]    o_path_length,
    output logic [spc_pkg::OUT_W-1:0]    o_path_cost,
    input  logic                         i_cfg_we,
    input  logic [spc_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [spc_pkg::COUNT_W-1:0]  i_cfg_data
);

    import spc_pkg::*;

    localparam int NB     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW     = $clog2(MAX_NODES + 1);
    localparam int DEPTH  = MAX_NODES * MAX_NODES;
    localparam int AW     = $clog2(DEPTH);
    localparam int W      = WEIGHT_BITS;
    localparam int DATA_W = 2 * W + 1;
    localparam int DW     = W + NB;
    localparam int SW     = (DW > OUT_W) ? DW : OUT_W;

    t_state r_state, n_state;

    logic [COUNT_W-1:0] r_node_count;
    logic [NODE_W-1:0]  r_src, r_dst;

    logic [AW-1:0]      r_clr, n_clr;
    logic [AW-1:0]      r_addr2, n_addr2;
    logic [DATA_W-1:0]  r_wdata2, n_wdata2;

    logic [NB-1:0]      r_u, n_u;
    logic [DW-1:0]      r_ud, n_ud, r_uc, n_uc;
    logic [NB-1:0]      r_v, n_v;
    logic               r_issue, n_issue;
    logic [NB-1:0]      r_v1, n_v1;
    logic               r_s1, n_s1;
    logic               r_found, n_found;
    logic [NB-1:0]      r_best, n_best;
    logic [DW-1:0]      r_bd, n_bd, r_bc, n_bc;
    logic [MAX_NODES-1:0] r_settled, n_settled, r_reached, n_reached;
    logic               r_oob, n_oob;

    logic               r_ov, n_ov;
    logic               r_oreach, n_oreach;
    logic [OUT_W-1:0]   r_olen, n_olen, r_ocost, n_ocost;

    logic               e_we;
    logic [AW-1:0]      e_waddr, e_raddr;
    logic [DATA_W-1:0]  e_wdata, e_rdata;

    logic [DW-1:0]      r_dist_mem [MAX_NODES];
    logic [DW-1:0]      r_cost_mem [MAX_NODES];
    logic [DW-1:0]      r_dv, r_cv;
    logic               m_we;
    logic [NB-1:0]      m_waddr, m_raddr;
    logic [DW-1:0]      m_wd, m_wc;

    logic [CW-1:0]      n_act;
    logic               accept;
    logic               ep_ok;
    logic [NB-1:0]      a_idx, b_idx, src_idx, dst_idx;
    logic [DATA_W-1:0]  ld_word;

    logic               e_present;
    logic [W-1:0]       e_len, e_cost;
    logic [DW-1:0]      nd, nc, cd, cc;
    logic               upd, cand;
    logic [SW-1:0]      ext_d, ext_c;

    always_comb begin
        if (r_node_count == '0) begin
            n_act = CW'(1);
        end else if (32'(r_node_count) > MAX_NODES) begin
            n_act = CW'(MAX_NODES);
        end else begin
            n_act = CW'(r_node_count);
        end
    end

    assign a_idx   = NB'(i_node_a);
    assign b_idx   = NB'(i_node_b);
    assign src_idx = NB'(r_src);
    assign dst_idx = NB'(r_dst);
    assign ep_ok   = (32'(i_node_a) < MAX_NODES) && (32'(i_node_b) < MAX_NODES);
    assign ld_word = {1'b1, W'(i_edge_length), W'(i_edge_cost)};

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= COUNT_W'(64);
            r_src        <= '0;
            r_dst        <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                C_NODE_COUNT: r_node_count <= i_cfg_data;
                C_SOURCE:     r_src        <= NODE_W'(i_cfg_data);
                C_DEST:       r_dst        <= NODE_W'(i_cfg_data);
                default:      ;
            endcase
        end
    end

    // stage 1 of the relax pass
    assign e_present = e_rdata[DATA_W-1];
    assign e_len     = e_rdata[2*W-1:W];
    assign e_cost    = e_rdata[W-1:0];
    assign nd        = r_ud + DW'(e_len);
    assign nc        = r_uc + DW'(e_cost);
    assign upd       = r_s1 && !r_settled[r_v1] && e_present &&
                       (!r_reached[r_v1] || nd < r_dv || (nd == r_dv && nc < r_cv));
    assign cd        = upd ? nd : r_dv;
    assign cc        = upd ? nc : r_cv;
    assign cand      = r_s1 && !r_settled[r_v1] && (r_reached[r_v1] || upd);

    assign ext_d = SW'(r_dv);
    assign ext_c = SW'(r_cv);

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_addr2   = r_addr2;
        n_wdata2  = r_wdata2;
        n_u       = r_u;
        n_ud      = r_ud;
        n_uc      = r_uc;
        n_v       = r_v;
        n_issue   = r_issue;
        n_v1      = r_v;
        n_s1      = 1'b0;
        n_found   = r_found;
        n_best    = r_best;
        n_bd      = r_bd;
        n_bc      = r_bc;
        n_settled = r_settled;
        n_reached = r_reached;
        n_oob     = r_oob;
        n_ov      = r_ov && !i_out_ready;
        n_oreach  = r_oreach;
        n_olen    = r_olen;
        n_ocost   = r_ocost;

        e_we    = 1'b0;
        e_waddr = r_clr;
        e_wdata = '0;
        e_raddr = AW'(AW'(r_u) * AW'(MAX_NODES) + AW'(r_v));
        m_we    = 1'b0;
        m_waddr = r_v1;
        m_wd    = nd;
        m_wc    = nc;
        m_raddr = r_v;

        case (r_state)
            S_CLEAR: begin
                e_we  = 1'b1;
                n_clr = r_clr + AW'(1);
                if (32'(r_clr) == DEPTH - 1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    case (t_kind'(i_kind))
                        K_LOAD: begin
                            if (ep_ok) begin
                                e_we     = 1'b1;
                                e_waddr  = AW'(AW'(a_idx) * AW'(MAX_NODES) + AW'(b_idx));
                                e_wdata  = ld_word;
                                n_addr2  = AW'(AW'(b_idx) * AW'(MAX_NODES) + AW'(a_idx));
                                n_wdata2 = ld_word;
                                n_state  = S_LOAD2;
                            end
                        end
                        K_CLEAR: begin
                            n_clr   = '0;
                            n_state = S_CLEAR;
                        end
                        K_RUN: begin
                            if (32'(r_src) >= 32'(n_act) || 32'(r_dst) >= 32'(n_act)) begin
                                n_oob   = 1'b1;
                                n_state = S_RESULT;
                            end else begin
                                n_oob   = 1'b0;
                                n_state = S_INIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LOAD2: begin
                e_we    = 1'b1;
                e_waddr = r_addr2;
                e_wdata = r_wdata2;
                n_state = S_IDLE;
            end
            S_INIT: begin
                m_we      = 1'b1;
                m_waddr   = src_idx;
                m_wd      = '0;
                m_wc      = '0;
                n_settled = '0;
                n_reached = '0;
                n_settled[src_idx] = 1'b1;
                n_reached[src_idx] = 1'b1;
                n_u       = src_idx;
                n_ud      = '0;
                n_uc      = '0;
                n_v       = '0;
                n_issue   = 1'b1;
                n_found   = 1'b0;
                n_state   = S_PASS;
            end
            S_PASS: begin
                n_s1 = r_issue;
                if (r_issue) begin
                    if (32'(r_v) == 32'(n_act) - 1) begin
                        n_issue = 1'b0;
                    end else begin
                        n_v = r_v + NB'(1);
                    end
                end
                if (upd) begin
                    m_we = 1'b1;
                    n_reached[r_v1] = 1'b1;
                end
                if (cand && (!r_found || cd < r_bd)) begin
                    n_found = 1'b1;
                    n_best  = r_v1;
                    n_bd    = cd;
                    n_bc    = cc;
                end
                if (r_s1 && 32'(r_v1) == 32'(n_act) - 1) begin
                    if (n_found) begin
                        n_u       = n_best;
                        n_ud      = n_bd;
                        n_uc      = n_bc;
                        n_settled[n_best] = 1'b1;
                        n_v       = '0;
                        n_issue   = 1'b1;
                        n_found   = 1'b0;
                    end else begin
                        n_state = S_READ_DEST;
                    end
                end
            end
            S_READ_DEST: begin
                m_raddr = dst_idx;
                n_state = S_RESULT;
            end
            S_RESULT: begin
                m_raddr = dst_idx;
                if (!r_ov || i_out_ready) begin
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                    if (!r_oob && r_reached[dst_idx]) begin
                        n_oreach = 1'b1;
                        n_olen   = (ext_d > SW'(OUT_MAX)) ? OUT_MAX : OUT_W'(ext_d);
                        n_ocost  = (ext_c > SW'(OUT_MAX)) ? OUT_MAX : OUT_W'(ext_c);
                    end else begin
                        n_oreach = 1'b0;
                        n_olen   = '0;
                        n_ocost  = '0;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_issue   <= 1'b0;
            r_s1      <= 1'b0;
            r_found   <= 1'b0;
            r_settled <= '0;
            r_reached <= '0;
            r_oob     <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_issue   <= n_issue;
            r_s1      <= n_s1;
            r_found   <= n_found;
            r_settled <= n_settled;
            r_reached <= n_reached;
            r_oob     <= n_oob;
            r_ov      <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr2  <= n_addr2;
        r_wdata2 <= n_wdata2;
        r_u      <= n_u;
        r_ud     <= n_ud;
        r_uc     <= n_uc;
        r_v      <= n_v;
        r_v1     <= n_v1;
        r_best   <= n_best;
        r_bd     <= n_bd;
        r_bc     <= n_bc;
        r_oreach <= n_oreach;
        r_olen   <= n_olen;
        r_ocost  <= n_ocost;
    end

    // node distance and cost memories
    always_ff @(posedge i_clk) begin
        if (m_we) begin
            r_dist_mem[m_waddr] <= m_wd;
            r_cost_mem[m_waddr] <= m_wc;
        end
        r_dv <= r_dist_mem[m_raddr];
        r_cv <= r_cost_mem[m_raddr];
    end

    spc_edge_ram #(
        .DEPTH  (DEPTH),
        .AW     (AW),
        .DATA_W (DATA_W)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata)
    );

    assign o_out_valid   = r_ov;
    assign o_reachable   = r_oreach;
    assign o_path_length = r_olen;
    assign o_path_cost   = r_ocost;

endmodule
